// ===== hw/rtl/led_mode_blink_engine_core_defines.svh =====
// Assertion macros used by the checker of this block.
`ifndef LED_MODE_BLINK_ENGINE_CORE_DEFINES_SVH
`define LED_MODE_BLINK_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LMBE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LMBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/lmbe_pkg.sv =====
package lmbe_pkg;

  localparam int unsigned NumLeds = 8;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CntW    = 4;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ColorW  = 4;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned HalfW   = 16;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned CfgAW = ModeW + ColorW;
  localparam int unsigned CfgBW = 1 + TimeW;

  localparam logic [CntW-1:0]  LedsReset = CntW'(8);
  localparam logic [HalfW-1:0] HalfReset = HalfW'(500);

  localparam logic CFG_LEDS_IN_USE   = 1'b0;
  localparam logic CFG_BLINK_HALF_MS = 1'b1;

  localparam logic ACT_SET_MODE = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  localparam logic [ModeW-1:0] MODE_OFF   = 2'd0;
  localparam logic [ModeW-1:0] MODE_ON    = 2'd1;
  localparam logic [ModeW-1:0] MODE_BLINK = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  function automatic rgb_t palette(input logic [ColorW-1:0] id);
    rgb_t c;
    c = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    case (id)
      4'd1:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
      4'd2:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      4'd3:    c = '{red: 8'd0,   green: 8'd128, blue: 8'd0};
      4'd4:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      4'd5:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
      4'd6:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
      4'd7:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
      4'd8:    c = '{red: 8'd255, green: 8'd165, blue: 8'd0};
      4'd9:    c = '{red: 8'd128, green: 8'd0,   blue: 8'd128};
      4'd10:   c = '{red: 8'd255, green: 8'd192, blue: 8'd203};
      default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/lmbe_ram.sv =====
module lmbe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/led_mode_blink_engine_core.sv =====
// LED mode and blink engine. A set-mode transfer (tuser 0) writes the mode and
// palette colour of one LED and gives no output; an index at or beyond the LED
// count is dropped. A tick transfer (tuser 1) carries the millisecond time and
// walks the LEDs in use (leds_in_use, capped at eight) from index 0, giving one
// colour transfer per LED with tlast on the final one. The per-LED state lives
// in two 8-entry RAMs with a registered read, and the walk reads the next entry
// while it writes back the current one. The walk stalls while a result waits
// for the output side. The input is held off while a tick walk is in progress.
// Configuration writes are taken in any cycle.
module led_mode_blink_engine_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [lmbe_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: led_index[2:0], mode[4:3], color_id[8:5], now_ms[40:9], zero fill.
  input  logic [lmbe_pkg::InDataW-1:0]     s_axis_tdata,
  // tuser: action.
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: out_index[2:0], red[10:3], green[18:11], blue[26:19], zero fill.
  output logic [lmbe_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);

  logic [lmbe_pkg::CntW-1:0]  leds_q;
  logic [lmbe_pkg::HalfW-1:0] half_q;

  lmbe_pkg::state_e state_q, state_d;
  logic [lmbe_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [lmbe_pkg::CntW-1:0]  count_q, count_d;
  logic [lmbe_pkg::TimeW-1:0] now_q, now_d;

  logic [lmbe_pkg::NumLeds-1:0] va_q, va_d;
  logic [lmbe_pkg::NumLeds-1:0] vb_q, vb_d;
  logic va_rd_q, va_rd_d;
  logic vb_rd_q, vb_rd_d;

  logic                          out_valid_q, out_valid_d;
  logic [lmbe_pkg::IdxW-1:0]     out_index_q, out_index_d;
  lmbe_pkg::rgb_t                out_rgb_q, out_rgb_d;
  logic                          out_last_q, out_last_d;

  logic [lmbe_pkg::IdxW-1:0]     in_index;
  logic [lmbe_pkg::ModeW-1:0]    in_mode;
  logic [lmbe_pkg::ColorW-1:0]   in_color;
  logic [lmbe_pkg::TimeW-1:0]    in_now;

  logic [lmbe_pkg::CntW-1:0]     count_eff;
  logic                          accept;
  logic                          tick_go;
  logic                          set_we;
  logic                          advance;
  logic                          is_last;

  logic                          re;
  logic [lmbe_pkg::IdxW-1:0]     raddr;
  logic [lmbe_pkg::CfgAW-1:0]    a_wdata, a_rdata;
  logic [lmbe_pkg::CfgBW-1:0]    b_wdata, b_rdata;

  logic [lmbe_pkg::ModeW-1:0]    cur_mode;
  logic [lmbe_pkg::ColorW-1:0]   cur_color;
  logic [lmbe_pkg::TimeW-1:0]    cur_time;
  logic                          cur_lit;
  logic [lmbe_pkg::TimeW-1:0]    elapsed;
  logic                          toggle;
  logic                          new_lit;
  logic [lmbe_pkg::TimeW-1:0]    new_time;
  lmbe_pkg::rgb_t                cur_rgb;

  assign in_index = s_axis_tdata[2:0];
  assign in_mode  = s_axis_tdata[4:3];
  assign in_color = s_axis_tdata[8:5];
  assign in_now   = s_axis_tdata[40:9];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leds_q <= lmbe_pkg::LedsReset;
      half_q <= lmbe_pkg::HalfReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == lmbe_pkg::CFG_LEDS_IN_USE) begin
        leds_q <= cfg_data_i[lmbe_pkg::CntW-1:0];
      end else begin
        half_q <= cfg_data_i[lmbe_pkg::HalfW-1:0];
      end
    end
  end

  assign count_eff = (leds_q > lmbe_pkg::CntW'(lmbe_pkg::NumLeds))
                   ? lmbe_pkg::CntW'(lmbe_pkg::NumLeds) : leds_q;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign tick_go = accept && (s_axis_tuser == lmbe_pkg::ACT_TICK)
                   && (count_eff != '0);
  assign set_we  = accept && (s_axis_tuser == lmbe_pkg::ACT_SET_MODE)
                   && ({1'b0, in_index} < count_eff);
  assign advance = (state_q == lmbe_pkg::ST_WALK)
                   && (!out_valid_q || m_axis_tready);
  assign is_last = (({1'b0, idx_q} + lmbe_pkg::CntW'(1)) == count_q);

  assign re    = tick_go || (advance && !is_last);
  assign raddr = accept ? '0 : idx_q + lmbe_pkg::IdxW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      lmbe_pkg::ST_IDLE: begin
        if (tick_go) begin
          state_d = lmbe_pkg::ST_WALK;
        end
      end
      lmbe_pkg::ST_WALK: begin
        if (advance && is_last) begin
          state_d = lmbe_pkg::ST_IDLE;
        end
      end
      default: state_d = lmbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    case (state_q)
      lmbe_pkg::ST_IDLE: s_axis_tready = 1'b1;
      lmbe_pkg::ST_WALK: s_axis_tready = 1'b0;
      default:           s_axis_tready = 1'b0;
    endcase
  end

  assign a_wdata = {in_mode, in_color};

  lmbe_ram #(
    .Width(lmbe_pkg::CfgAW),
    .Depth(lmbe_pkg::NumLeds)
  ) u_ram_mode (
    .clk_i  (clk_i),
    .we_i   (set_we),
    .waddr_i(in_index),
    .wdata_i(a_wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(a_rdata)
  );

  lmbe_ram #(
    .Width(lmbe_pkg::CfgBW),
    .Depth(lmbe_pkg::NumLeds)
  ) u_ram_blink (
    .clk_i  (clk_i),
    .we_i   (advance),
    .waddr_i(idx_q),
    .wdata_i(b_wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(b_rdata)
  );

  // Entries never written read as their reset value.
  always_comb begin
    cur_mode  = va_rd_q ? a_rdata[lmbe_pkg::CfgAW-1:lmbe_pkg::ColorW] : lmbe_pkg::MODE_OFF;
    cur_color = va_rd_q ? a_rdata[lmbe_pkg::ColorW-1:0] : '0;
    cur_lit   = vb_rd_q ? b_rdata[lmbe_pkg::TimeW] : 1'b0;
    cur_time  = vb_rd_q ? b_rdata[lmbe_pkg::TimeW-1:0] : '0;
    elapsed   = now_q - cur_time;
    toggle    = (cur_mode == lmbe_pkg::MODE_BLINK)
                && (elapsed > {{(lmbe_pkg::TimeW-lmbe_pkg::HalfW){1'b0}}, half_q});
    new_lit   = cur_lit ^ toggle;
    new_time  = toggle ? now_q : cur_time;
    if ((cur_mode == lmbe_pkg::MODE_ON)
        || ((cur_mode == lmbe_pkg::MODE_BLINK) && new_lit)) begin
      cur_rgb = lmbe_pkg::palette(cur_color);
    end else begin
      cur_rgb = lmbe_pkg::palette('0);
    end
  end

  assign b_wdata = {new_lit, new_time};

  always_comb begin
    idx_d   = idx_q;
    count_d = count_q;
    now_d   = now_q;
    va_d    = va_q;
    vb_d    = vb_q;
    va_rd_d = va_rd_q;
    vb_rd_d = vb_rd_q;
    if (tick_go) begin
      idx_d   = '0;
      count_d = count_eff;
      now_d   = in_now;
    end else if (advance) begin
      idx_d = idx_q + lmbe_pkg::IdxW'(1);
    end
    if (set_we) begin
      va_d[in_index] = 1'b1;
    end
    if (advance) begin
      vb_d[idx_q] = 1'b1;
    end
    if (re) begin
      va_rd_d = va_q[raddr];
      vb_rd_d = vb_q[raddr];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_index_d = out_index_q;
    out_rgb_d   = out_rgb_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_index_d = idx_q;
      out_rgb_d   = cur_rgb;
      out_last_d  = is_last;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmbe_pkg::ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      va_q        <= '0;
      vb_q        <= '0;
      va_rd_q     <= 1'b0;
      vb_rd_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      va_q        <= va_d;
      vb_q        <= vb_d;
      va_rd_q     <= va_rd_d;
      vb_rd_q     <= vb_rd_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    out_index_q <= out_index_d;
    out_rgb_q   <= out_rgb_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red,
                          out_index_q};

endmodule

// ===== hw/rtl/lmbe_checker.sv =====
`include "led_mode_blink_engine_core_defines.svh"

module lmbe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lmbe_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // A result that is offered stays offered until it is taken.
  `LMBE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // A result that waits keeps its contents.
  `LMBE_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
                    $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // A set-mode transfer never produces a result.
  `LMBE_ASSERT_NEXT(a_set_quiet, s_axis_tvalid && s_axis_tready && !s_axis_tuser
                    && !m_axis_tvalid, !m_axis_tvalid)

  // While a tick still has results to come, no new input is taken.
  `LMBE_ASSERT_NOW(a_walk_busy, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

  // A configuration write is always taken.
  `LMBE_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind led_mode_blink_engine_core lmbe_checker u_lmbe_checker (.*);

// ===== tb/tb_led_mode_blink_engine_core.sv =====
module tb_led_mode_blink_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 800000;
  localparam int DrainLimit = 20000;
  localparam int TailCycles = 24;
  localparam int HoldCycles = 400;
  localparam int NumRows    = 30;
  localparam int NumPhases  = 7;
  localparam logic [lmbe_pkg::ModeW-1:0] ModeBad = 2'd3;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic                        act;
    logic [lmbe_pkg::IdxW-1:0]   idx;
    logic [lmbe_pkg::ModeW-1:0]  md;
    logic [lmbe_pkg::ColorW-1:0] col;
    logic [lmbe_pkg::TimeW-1:0]  stamp;
    logic                        reg_sel;
    logic [lmbe_pkg::HalfW-1:0]  reg_val;
    logic                        dark;
  } row_t;

  typedef struct packed {
    logic [lmbe_pkg::IdxW-1:0] led;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic                      last;
  } pixel_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic                          cfg_index_i;
  logic [lmbe_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [lmbe_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [lmbe_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tlast;

  led_mode_blink_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Colors are packed as red in the top byte, then green, then blue.
  logic [23:0] shade [16] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h008000,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
    24'hFFA500, 24'h800080, 24'hFFC0CB, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000
  };

  row_t plan [NumRows] = '{
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b1},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd0, lmbe_pkg::MODE_ON,    4'd1,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd1, lmbe_pkg::MODE_ON,    4'd10, 32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd2, lmbe_pkg::MODE_BLINK, 4'd8,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd3, lmbe_pkg::MODE_BLINK, 4'd9,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd4, ModeBad,              4'd2,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd5, lmbe_pkg::MODE_ON,    4'd15, 32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd6, lmbe_pkg::MODE_ON,    4'd3,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd7, lmbe_pkg::MODE_BLINK, 4'd5,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd500,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd501,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd7, ModeBad,              4'd15, 32'hFFFF_FFFF,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd500,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd2, lmbe_pkg::MODE_ON,    4'd6,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd3, lmbe_pkg::MODE_ON,    4'd4,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd4, lmbe_pkg::MODE_BLINK, 4'd7,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd5, lmbe_pkg::MODE_ON,    4'd2,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd7, ModeBad,              4'd15, 32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'hAAAA_AAAA,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_REG,  lmbe_pkg::ACT_SET_MODE, 3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd0, lmbe_pkg::MODE_ON,    4'd1,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'h5555_5555,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b1},
    '{ROW_REG,  lmbe_pkg::ACT_SET_MODE, 3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd3, 1'b0},
    '{ROW_REG,  lmbe_pkg::ACT_SET_MODE, 3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd0,
      lmbe_pkg::CFG_BLINK_HALF_MS, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_SET_MODE, 3'd5, lmbe_pkg::MODE_ON,    4'd1,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd1,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_REG,  lmbe_pkg::ACT_SET_MODE, 3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd0,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd15, 1'b0},
    '{ROW_REG,  lmbe_pkg::ACT_SET_MODE, 3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd0,
      lmbe_pkg::CFG_BLINK_HALF_MS, 16'hFFFF, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'd2,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0},
    '{ROW_ITEM, lmbe_pkg::ACT_TICK,     3'd0, lmbe_pkg::MODE_OFF,   4'd0,  32'h0001_0003,
      lmbe_pkg::CFG_LEDS_IN_USE, 16'd0, 1'b0}
  };

  int phase_leds [NumPhases] = '{8, 1, 0, 15, 5, 8, 3};
  int phase_half [NumPhases] = '{0, 65535, 20, 500, 1, 3, 700};
  int phase_len  [NumPhases] = '{55, 55, 15, 55, 55, 55, 55};

  logic [lmbe_pkg::CntW-1:0]   leds_cfg = lmbe_pkg::LedsReset;
  logic [lmbe_pkg::HalfW-1:0]  half_cfg = lmbe_pkg::HalfReset;
  logic [lmbe_pkg::ModeW-1:0]  mode_tab  [lmbe_pkg::NumLeds] = '{default: lmbe_pkg::MODE_OFF};
  logic [lmbe_pkg::ColorW-1:0] color_tab [lmbe_pkg::NumLeds] = '{default: '0};
  logic [lmbe_pkg::TimeW-1:0]  flip_at   [lmbe_pkg::NumLeds] = '{default: '0};
  logic                        lit       [lmbe_pkg::NumLeds] = '{default: 1'b0};

  pixel_t      pending_colors [$];
  int          errors = 0;
  bit          rx_idle_on = 1'b1;
  bit          tx_idle_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [31:0] wall_ms = '0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic check_field(input string name, input int led, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("led %0d %s got %0d want %0d", led, name, got, want));
  endtask

  function automatic void update_leds(input logic act, input logic [lmbe_pkg::IdxW-1:0] idx,
                                      input logic [lmbe_pkg::ModeW-1:0] md,
                                      input logic [lmbe_pkg::ColorW-1:0] col,
                                      input logic [lmbe_pkg::TimeW-1:0] stamp, input bit dark);
    int n;
    logic [23:0] rgb;
    n = (leds_cfg > lmbe_pkg::NumLeds) ? int'(lmbe_pkg::NumLeds) : int'(leds_cfg);
    if (act == lmbe_pkg::ACT_SET_MODE) begin
      if (idx < n) begin
        mode_tab[idx]  = md;
        color_tab[idx] = col;
      end
      return;
    end
    for (int i = 0; i < n; i++) begin
      rgb = '0;
      if (mode_tab[i] == lmbe_pkg::MODE_ON) begin
        rgb = shade[color_tab[i]];
      end else if (mode_tab[i] == lmbe_pkg::MODE_BLINK) begin
        if (stamp - flip_at[i] > 32'(half_cfg)) begin
          lit[i]     = ~lit[i];
          flip_at[i] = stamp;
        end
        if (lit[i]) rgb = shade[color_tab[i]];
      end
      if (dark) rgb = '0;
      pending_colors.push_back(pixel_t'{3'(i), rgb[23:16], rgb[15:8], rgb[7:0], i == n - 1});
    end
  endfunction

  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic act, input logic [lmbe_pkg::IdxW-1:0] idx,
                           input logic [lmbe_pkg::ModeW-1:0] md,
                           input logic [lmbe_pkg::ColorW-1:0] col,
                           input logic [lmbe_pkg::TimeW-1:0] stamp, input bit dark);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'd0, stamp, col, md, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    update_leds(act, idx, md, col, stamp, dark);
  endtask

  task automatic write_reg(input logic sel, input logic [lmbe_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (sel == lmbe_pkg::CFG_LEDS_IN_USE) leds_cfg = val[lmbe_pkg::CntW-1:0];
    else half_cfg = val;
  endtask

  task automatic drain();
    int spin;
    spin = 0;
    while (pending_colors.size() != 0 && spin < DrainLimit) begin
      @(posedge clk_i);
      spin++;
    end
    if (pending_colors.size() != 0) begin
      flag_mismatch($sformatf("%0d color transfers never arrived", pending_colors.size()));
      pending_colors.delete();
    end
    repeat (TailCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : watch_out
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_colors.size() == 0) begin
        flag_mismatch($sformatf("unexpected output transfer, tdata %h", m_axis_tdata));
      end else begin
        want = pending_colors.pop_front();
        check_field("index", want.led, m_axis_tdata[2:0], want.led);
        check_field("red", want.led, m_axis_tdata[10:3], want.red);
        check_field("green", want.led, m_axis_tdata[18:11], want.green);
        check_field("blue", want.led, m_axis_tdata[26:19], want.blue);
        check_field("last", want.led, m_axis_tlast, want.last);
      end
    end
  end

  initial begin : rx_side
    int r;
    int n;
    m_axis_tready <= 1'b0;
    wait (rst_ni == 1'b1);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (!rx_idle_on || r < 55) begin
          m_axis_tready <= 1'b1;
          n = rx_idle_on ? $urandom_range(1, 4) : 1;
        end else if (r < 90) begin
          m_axis_tready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          m_axis_tready <= 1'b0;
          n = $urandom_range(8, 30);
        end
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int r;
    int leds_v;
    int half_v;
    logic [lmbe_pkg::IdxW-1:0]   idx;
    logic [lmbe_pkg::ModeW-1:0]  md;
    logic [lmbe_pkg::ColorW-1:0] col;
    logic [lmbe_pkg::TimeW-1:0]  delta;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < NumRows; k++) begin
      if (plan[k].kind == ROW_REG) begin
        if (k == 0 || plan[k-1].kind != ROW_REG) begin
          s_axis_tvalid <= 1'b0;
          drain();
        end
        write_reg(plan[k].reg_sel, plan[k].reg_val);
        if (k == NumRows - 1 || plan[k+1].kind != ROW_REG) cfg_valid_i <= 1'b0;
      end else begin
        send_item(plan[k].act, plan[k].idx, plan[k].md, plan[k].col, plan[k].stamp,
                  plan[k].dark);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      s_axis_tvalid <= 1'b0;
      drain();
      leds_v = phase_leds[p];
      half_v = phase_half[p];
      if (p == NumPhases - 1) begin
        leds_v = $urandom_range(0, 15);
        half_v = $urandom_range(0, 65535);
      end
      write_reg(lmbe_pkg::CFG_LEDS_IN_USE, lmbe_pkg::CfgDataW'(leds_v));
      write_reg(lmbe_pkg::CFG_BLINK_HALF_MS, lmbe_pkg::CfgDataW'(half_v));
      cfg_valid_i <= 1'b0;
      rx_idle_on = (p % 3) != 2;
      tx_idle_on = (p % 3) != 1;
      if (p == 1) hold_req = 1'b1;
      if (p == 4) wall_ms = 32'hFFFF_FF00;
      for (int j = 0; j < phase_len[p]; j++) begin
        r   = $urandom_range(0, 99);
        idx = lmbe_pkg::IdxW'($urandom_range(0, 7));
        col = lmbe_pkg::ColorW'($urandom_range(0, 15));
        if (r < 40) begin
          r = $urandom_range(0, 99);
          if (r < 45) md = lmbe_pkg::MODE_BLINK;
          else if (r < 75) md = lmbe_pkg::MODE_ON;
          else if (r < 90) md = lmbe_pkg::MODE_OFF;
          else md = ModeBad;
          send_item(lmbe_pkg::ACT_SET_MODE, idx, md, col, $urandom, 1'b0);
        end else begin
          r = $urandom_range(0, 9);
          if (r < 4) delta = 32'(int'(half_cfg) + $urandom_range(0, 2) - 1);
          else if (r < 8) delta = $urandom_range(0, 2 * int'(half_cfg) + 2);
          else if (r == 8) delta = $urandom;
          else delta = '0;
          wall_ms = wall_ms + delta;
          md = lmbe_pkg::ModeW'($urandom_range(0, 3));
          send_item(lmbe_pkg::ACT_TICK, idx, md, col, wall_ms, 1'b0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
